// File: hdl/vff_pkg.sv
package vff_pkg;

  // Fixed formats
  localparam int COORD_W            = 32;
  localparam int COORD_FRAC_BITS    = 16;
  localparam int FACTOR_W           = 17;
  localparam int EXP_TABLE_BITS_DEF = 6;
  localparam int EXP_ARG_W          = 20;   // exp argument, unsigned Q4.16
  localparam int RECIP_BITS         = 48;
  localparam int RECIP_W            = RECIP_BITS + 1;
  localparam int RECIP_LO_W         = 25;   // low slice of the reciprocal multiply
  localparam int MAG_W              = 33;   // linear numerator magnitude

  localparam logic [FACTOR_W-1:0] ONE_Q16 = FACTOR_W'(65536);

  // Stream payload widths
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Fog modes
  localparam logic [1:0] MODE_LINEAR = 2'd0;
  localparam logic [1:0] MODE_EXP    = 2'd1;
  localparam logic [1:0] MODE_EXP2   = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DENSITY = 2'd3;

  // Per-stage advance enables for the shared pipeline
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } vff_adv_t;

  // One exp(-x) table entry, Q16: series for exp(-t/256), eight squarings, round
  function automatic logic [FACTOR_W-1:0] exp_entry(input int unsigned k,
                                                    input int unsigned tbits);
    logic [63:0] t;
    logic [63:0] u;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] rnd;
    t    = 64'(k) << (35 - tbits);
    u    = t >> 8;
    sum  = 64'd1 << 31;
    term = 64'd1 << 31;
    term = (term * u) >> 31;
    sum  = sum - term;
    term = ((term * u) >> 31) / 2;
    sum  = sum + term;
    term = ((term * u) >> 31) / 3;
    sum  = sum - term;
    term = ((term * u) >> 31) / 4;
    sum  = sum + term;
    term = ((term * u) >> 31) / 5;
    sum  = sum - term;
    term = ((term * u) >> 31) / 6;
    sum  = sum + term;
    for (int n = 0; n < 8; n++) begin
      sum = (sum * sum + (64'd1 << 30)) >> 31;
    end
    rnd = (sum + 64'd16384) >> 15;
    return rnd[FACTOR_W-1:0];
  endfunction

endpackage

// File: hdl/vff_recip.sv
module vff_recip import vff_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      load,
  input  logic signed [COORD_W-1:0] fog_start,
  input  logic signed [COORD_W-1:0] fog_end,
  output logic [RECIP_W-1:0]        recip,
  output logic                      recip_neg,
  output logic                      busy
);

  localparam int CNT_W = $clog2(RECIP_W);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_PREP = 3'b010,
    ST_DIV  = 3'b100
  } recip_state_t;

  recip_state_t             state_r, state_nxt;
  logic signed [COORD_W:0]  diff_r, diff_nxt;
  logic [COORD_W-1:0]       dvsr_r, dvsr_nxt;
  logic [COORD_W-1:0]       rem_r, rem_nxt;
  logic [RECIP_W-1:0]       dvd_r, dvd_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [RECIP_W-1:0]       recip_r, recip_nxt;
  logic                     neg_r, neg_nxt;
  logic [COORD_W:0]         diff_mag;
  logic [COORD_W:0]         rem_sh;
  logic                     ge;

  // Magnitude of the start-to-end span
  assign diff_mag = diff_r[COORD_W] ? (~diff_r + 1'b1) : diff_r;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign rem_sh = {rem_r, dvd_r[RECIP_W-1]};
  assign ge     = (rem_sh >= {1'b0, dvsr_r});

  always_comb begin
    state_nxt = state_r;
    diff_nxt  = diff_r;
    dvsr_nxt  = dvsr_r;
    rem_nxt   = rem_r;
    dvd_nxt   = dvd_r;
    cnt_nxt   = cnt_r;
    recip_nxt = recip_r;
    neg_nxt   = neg_r;
    case (state_r)
      ST_IDLE: begin
        if (load) begin
          diff_nxt  = {fog_end[COORD_W-1], fog_end} - {fog_start[COORD_W-1], fog_start};
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        if (diff_r == '0) begin
          // Equal start and end: factor scale is 1.0
          recip_nxt = RECIP_W'(1) << (RECIP_BITS - COORD_FRAC_BITS);
          neg_nxt   = 1'b0;
          state_nxt = ST_IDLE;
        end else begin
          // Dividend 2^48 + mag/2 rounds the quotient to nearest
          dvsr_nxt  = diff_mag[COORD_W-1:0];
          dvd_nxt   = {1'b1, (RECIP_BITS - COORD_W + 1)'(0), diff_mag[COORD_W-1:1]};
          rem_nxt   = '0;
          cnt_nxt   = CNT_W'(RECIP_W - 1);
          neg_nxt   = diff_r[COORD_W];
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt = ge ? COORD_W'(rem_sh - {1'b0, dvsr_r}) : rem_sh[COORD_W-1:0];
        dvd_nxt = {dvd_r[RECIP_W-2:0], ge};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          recip_nxt = {dvd_r[RECIP_W-2:0], ge};
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    // A new write restarts the division
    if (load && state_r != ST_IDLE) begin
      diff_nxt  = {fog_end[COORD_W-1], fog_end} - {fog_start[COORD_W-1], fog_start};
      state_nxt = ST_PREP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      recip_r <= RECIP_W'(1) << 32;   // end 1.0, start 0
      neg_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      recip_r <= recip_nxt;
      neg_r   <= neg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    diff_r <= diff_nxt;
    dvsr_r <= dvsr_nxt;
    rem_r  <= rem_nxt;
    dvd_r  <= dvd_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign recip     = recip_r;
  assign recip_neg = neg_r;
  assign busy      = load || (state_r != ST_IDLE);

endmodule

// File: hdl/vff_lin.sv
module vff_lin import vff_pkg::*; (
  input  logic                      clk,
  input  vff_adv_t                  adv,
  input  logic [COORD_W-1:0]        az,
  input  logic signed [COORD_W-1:0] fog_end,
  input  logic [RECIP_W-1:0]        recip,
  input  logic                      recip_neg,
  output logic [FACTOR_W-1:0]       lin_f
);

  localparam int RECIP_HI_W = RECIP_W - RECIP_LO_W;
  localparam int PROD_W     = MAG_W + RECIP_W;

  logic signed [MAG_W:0]          num;
  logic [MAG_W-1:0]               mag_r;
  logic                           zero2_r, zero3_r;
  logic [MAG_W+RECIP_LO_W-1:0]    plo_r;
  logic [MAG_W+RECIP_HI_W-1:0]    phi_r;
  logic [PROD_W-1:0]              sum;
  logic [PROD_W-33:0]             scaled;
  logic [FACTOR_W-1:0]            lin_f_r;

  // Numerator taken in the sign that the reciprocal expects
  assign num = recip_neg ? ({2'b00, az} - {{2{fog_end[COORD_W-1]}}, fog_end})
                         : ({{2{fog_end[COORD_W-1]}}, fog_end} - {2'b00, az});

  // Stage 2: numerator magnitude, zero or wrong sign
  always_ff @(posedge clk) begin
    if (adv.s2) begin
      mag_r   <= num[MAG_W-1:0];
      zero2_r <= num[MAG_W] || (num == '0);
    end
  end

  // Stage 3: two partial products of magnitude times reciprocal
  always_ff @(posedge clk) begin
    if (adv.s3) begin
      plo_r   <= mag_r * recip[RECIP_LO_W-1:0];
      phi_r   <= mag_r * recip[RECIP_W-1:RECIP_LO_W];
      zero3_r <= zero2_r;
    end
  end

  // Stage 4: combine, drop 32 fraction bits, clamp to 1.0
  assign sum    = {phi_r, RECIP_LO_W'(0)} + PROD_W'(plo_r);
  assign scaled = sum[PROD_W-1:32];

  always_ff @(posedge clk) begin
    if (adv.s4) begin
      if (zero3_r) begin
        lin_f_r <= '0;
      end else if (scaled > (PROD_W-32)'(ONE_Q16)) begin
        lin_f_r <= ONE_Q16;
      end else begin
        lin_f_r <= scaled[FACTOR_W-1:0];
      end
    end
  end

  assign lin_f = lin_f_r;

endmodule

// File: hdl/vff_exp.sv
module vff_exp import vff_pkg::*; #(
  parameter int EXP_TABLE_BITS = EXP_TABLE_BITS_DEF
) (
  input  logic                  clk,
  input  vff_adv_t              adv,
  input  logic [COORD_W-1:0]    az,
  input  logic [CFG_DATA_W-1:0] fog_density,
  input  logic [1:0]            fog_mode,
  output logic [FACTOR_W-1:0]   exp_f
);

  localparam int SB     = EXP_ARG_W - EXP_TABLE_BITS;
  localparam int TBL_N  = 1 << EXP_TABLE_BITS;
  localparam int F      = COORD_FRAC_BITS;
  localparam int PROD_W = CFG_DATA_W + COORD_W;
  localparam int SQ_IN  = EXP_ARG_W - 2;

  logic [FACTOR_W-1:0]       rom [0:TBL_N];
  logic [PROD_W-1:0]         prod_r;
  logic [2*SQ_IN-1:0]        sq;
  logic                      sat_exp, sat_exp2;
  logic [EXP_ARG_W-1:0]      arg_r;
  logic                      sat3_r, sat4_r;
  logic [EXP_TABLE_BITS:0]   idx_a, idx_b;
  logic [FACTOR_W-1:0]       ta, tb;
  logic [FACTOR_W-1:0]       a_r, d_r;
  logic                      up_r;
  logic [SB-1:0]             fr_r;
  logic [FACTOR_W+SB-1:0]    step_prod;
  logic [FACTOR_W-1:0]       step;

  // exp(-x) segment ends over [0,16], both ends included
  for (genvar k = 0; k <= TBL_N; k++) begin : g_rom
    assign rom[k] = exp_entry(k, EXP_TABLE_BITS);
  end

  // Stage 2: density times |z|
  always_ff @(posedge clk) begin
    if (adv.s2) begin
      prod_r <= fog_density * az;
    end
  end

  // Stage 3: argument in Q.16, squared for exp2, range saturation
  assign sq       = prod_r[F+SQ_IN-1:F] * prod_r[F+SQ_IN-1:F];
  assign sat_exp  = |prod_r[PROD_W-1:F+EXP_ARG_W];
  assign sat_exp2 = |prod_r[PROD_W-1:F+SQ_IN];

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      if (fog_mode == MODE_EXP2) begin
        arg_r  <= sq[2*SQ_IN-1:16];
        sat3_r <= sat_exp2;
      end else begin
        arg_r  <= prod_r[F+EXP_ARG_W-1:F];
        sat3_r <= sat_exp;
      end
    end
  end

  // Stage 4: fetch both segment ends, hold slope magnitude and direction
  assign idx_a = {1'b0, arg_r[EXP_ARG_W-1:SB]};
  assign idx_b = idx_a + 1'b1;
  assign ta    = rom[idx_a];
  assign tb    = rom[idx_b];

  always_ff @(posedge clk) begin
    if (adv.s4) begin
      a_r    <= ta;
      up_r   <= (ta < tb);
      d_r    <= (ta < tb) ? (tb - ta) : (ta - tb);
      fr_r   <= arg_r[SB-1:0];
      sat4_r <= sat3_r;
    end
  end

  // Interpolate within the segment; output stage registers the result
  assign step_prod = d_r * fr_r;
  assign step      = step_prod[FACTOR_W+SB-1:SB];
  assign exp_f     = sat4_r ? '0 : (up_r ? (a_r + step) : (a_r - step));

endmodule

// File: hdl/vertex_fog_factor.sv
// Vertex fog factor: one signed Q16.16 fog coordinate per in_ transaction, one
// clamped Q1.16 fog factor (0..65536) per out_ transaction, in linear, exp or
// exp2 mode as set by fog_mode; fog_mode 3 gives 1.0. The block takes one
// vertex every cycle unless the pipeline is full and stalled or a reciprocal
// update holds in_tready low; out_tready low stalls the five-register pipeline,
// whose empty stages still fill. A write to fog_start or fog_end starts a
// one-bit-per-cycle divider for the linear reciprocal (49 quotient bits),
// which holds in_tready low after the write until the reciprocal is rebuilt;
// other writes take effect at once.
module vertex_fog_factor import vff_pkg::*; #(
  parameter int EXP_TABLE_BITS = EXP_TABLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata: fog_coord [31:0]
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tlast,
  // out_tdata: fog_factor [16:0], zero [23:17]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [1:0]                mode_r;
  logic signed [COORD_W-1:0] start_r;
  logic signed [COORD_W-1:0] end_r;
  logic [CFG_DATA_W-1:0]     density_r;
  logic                      recalc_r;

  logic [RECIP_W-1:0]        recip;
  logic                      recip_neg;
  logic                      busy;

  logic                      v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic                      l1_r, l2_r, l3_r, l4_r, out_last_r;
  logic                      adv1, adv5;
  vff_adv_t                  adv;
  logic [COORD_W-1:0]        z;
  logic [COORD_W-1:0]        az_r;
  logic [FACTOR_W-1:0]       lin_f;
  logic [FACTOR_W-1:0]       exp_f;
  logic [FACTOR_W-1:0]       out_f_r, out_f_nxt;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_LINEAR;
      start_r   <= '0;
      end_r     <= COORD_W'(65536);
      density_r <= CFG_DATA_W'(65536);
      recalc_r  <= 1'b0;
    end else begin
      recalc_r <= cfg_we && (cfg_index == REG_START || cfg_index == REG_END);
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE:    mode_r    <= cfg_wdata[1:0];
          REG_START:   start_r   <= cfg_wdata;
          REG_END:     end_r     <= cfg_wdata;
          REG_DENSITY: density_r <= cfg_wdata;
          default:     ;
        endcase
      end
    end
  end

  vff_recip u_recip (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (recalc_r),
    .fog_start (start_r),
    .fog_end   (end_r),
    .recip     (recip),
    .recip_neg (recip_neg),
    .busy      (busy)
  );

  // Stage advance: a stage moves when it is empty or the next one moves
  assign adv5   = !out_valid_r || out_tready;
  assign adv.s4 = !v4_r || adv5;
  assign adv.s3 = !v3_r || adv.s4;
  assign adv.s2 = !v2_r || adv.s3;
  assign adv1   = !v1_r || adv.s2;
  assign in_tready = adv1 && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv1)   v1_r        <= in_tvalid && in_tready;
      if (adv.s2) v2_r        <= v1_r;
      if (adv.s3) v3_r        <= v2_r;
      if (adv.s4) v4_r        <= v3_r;
      if (adv5)   out_valid_r <= v4_r;
    end
  end

  // Stage 1: coordinate magnitude (-2^31 maps to 2^31)
  assign z = in_tdata[COORD_W-1:0];

  always_ff @(posedge clk) begin
    if (adv1) begin
      az_r <= z[COORD_W-1] ? (~z + 1'b1) : z;
      l1_r <= in_tlast;
    end
    if (adv.s2) l2_r <= l1_r;
    if (adv.s3) l3_r <= l2_r;
    if (adv.s4) l4_r <= l3_r;
  end

  vff_lin u_lin (
    .clk       (clk),
    .adv       (adv),
    .az        (az_r),
    .fog_end   (end_r),
    .recip     (recip),
    .recip_neg (recip_neg),
    .lin_f     (lin_f)
  );

  vff_exp #(
    .EXP_TABLE_BITS (EXP_TABLE_BITS)
  ) u_exp (
    .clk         (clk),
    .adv         (adv),
    .az          (az_r),
    .fog_density (density_r),
    .fog_mode    (mode_r),
    .exp_f       (exp_f)
  );

  // Stage 5: pick the mode's factor into the output register
  always_comb begin
    case (mode_r)
      MODE_LINEAR: out_f_nxt = lin_f;
      MODE_EXP:    out_f_nxt = exp_f;
      MODE_EXP2:   out_f_nxt = exp_f;
      default:     out_f_nxt = ONE_Q16;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv5) begin
      out_f_r    <= out_f_nxt;
      out_last_r <= l4_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - FACTOR_W)'(0), out_f_r};
  assign out_tlast  = out_last_r;

endmodule

// File: hdl/vff_checker.sv
module vff_sva import vff_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast,
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_index
);

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // Factor never exceeds 1.0 and the pad bits stay clear
  a_factor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[16:0] <= 17'h10000) && (out_tdata[23:17] == '0))
    else $error("fog factor out of range");

  // A span write blocks new vertices while the reciprocal is rebuilt
  a_recip_block: assert property (@(posedge clk)
    rst_n && cfg_we && (cfg_index == REG_START || cfg_index == REG_END)
      |=> !in_tready ##1 !in_tready)
    else $error("vertex accepted during reciprocal update");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

endmodule

bind vertex_fog_factor vff_sva u_vff_sva (.*);

// File: tb/sv/vff_checker.sv
module vff_checker import vff_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tlast,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  out_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned           pending,
  output int unsigned           checked,
  output int unsigned           mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SEG_BITS  = EXP_TABLE_BITS_DEF;
  localparam int SEGS      = 1 << SEG_BITS;
  localparam int SEG_SHIFT = EXP_ARG_W - SEG_BITS;

  typedef struct {
    logic [FACTOR_W-1:0] factor;
    logic                last;
  } fog_result_t;

  fog_result_t         fog_expect_q[$];
  logic [FACTOR_W-1:0] decay_rom [0:SEGS];

  // Shadow copy of the fog registers and the derived linear reciprocal
  logic [1:0]         mode_q;
  logic signed [63:0] start_q;
  logic signed [63:0] end_q;
  logic [63:0]        dens_q;
  logic [63:0]        recip_q;
  logic               recip_neg_q;

  int unsigned err_total;
  int unsigned seen_total;
  fog_result_t want;

  function automatic logic signed [63:0] widen_signed(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  // Q16 sample of exp(-16k/SEGS): short series for a tiny step, then eight squarings
  function automatic logic [FACTOR_W-1:0] decay_point(input int unsigned k);
    logic [63:0] u;
    logic [63:0] acc;
    logic [63:0] term;
    logic [63:0] rounded;
    u    = (64'(k) << (35 - SEG_BITS)) >> 8;
    acc  = 64'd1 << 31;
    term = 64'd1 << 31;
    for (int n = 1; n <= 6; n++) begin
      term = ((term * u) >> 31) / 64'(n);
      if (n % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    for (int n = 0; n < 8; n++) begin
      acc = (acc * acc + (64'd1 << 30)) >> 31;
    end
    rounded = (acc + 64'd16384) >> 15;
    return rounded[FACTOR_W-1:0];
  endfunction

  // Piecewise-linear exp(-x), x in unsigned Q.16; zero from 16 up
  function automatic logic [FACTOR_W-1:0] decay_q16(input logic [63:0] x);
    logic [63:0] idx;
    logic [63:0] fr;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] r;
    if (x >= (64'd16 << 16)) begin
      return '0;
    end
    idx = (x >> SEG_SHIFT) & 64'(SEGS - 1);
    fr  = x & ((64'd1 << SEG_SHIFT) - 1);
    a   = 64'(decay_rom[idx]);
    b   = 64'(decay_rom[idx + 1]);
    if (a >= b) begin
      r = a - (((a - b) * fr) >> SEG_SHIFT);
    end else begin
      r = a + (((b - a) * fr) >> SEG_SHIFT);
    end
    return r[FACTOR_W-1:0];
  endfunction

  // Rebuild the linear reciprocal after start or end changes
  function automatic void refresh_recip();
    logic signed [63:0] diff;
    logic [63:0]        mag;
    diff = end_q - start_q;
    if (diff == 0) begin
      recip_q     = 64'd1 << (RECIP_BITS - COORD_FRAC_BITS);
      recip_neg_q = 1'b0;
    end else begin
      mag         = (diff < 0) ? 64'(-diff) : 64'(diff);
      recip_q     = ((64'd1 << RECIP_BITS) + mag / 2) / mag;
      recip_neg_q = (diff < 0);
    end
  endfunction

  // Fog factor of one coordinate under the current register copy
  function automatic logic [FACTOR_W-1:0] predict_fog(input logic [31:0] coord);
    logic signed [63:0] z;
    logic signed [63:0] num;
    logic [63:0]        az;
    logic [63:0]        x;
    logic [63:0]        mag;
    logic [63:0]        p;
    z  = widen_signed(coord);
    az = (z < 0) ? 64'(-z) : 64'(z);
    case (mode_q)
      MODE_LINEAR: begin
        num = end_q - $signed(az);
        if (num == 0 || (num > 0 && recip_neg_q) || (num < 0 && !recip_neg_q)) begin
          return '0;
        end
        mag = (num < 0) ? 64'(-num) : 64'(num);
        if (mag > ({64{1'b1}} / recip_q)) begin
          return ONE_Q16;
        end
        p = (mag * recip_q) >> (RECIP_BITS - 16);
        return (p > 64'(ONE_Q16)) ? ONE_Q16 : p[FACTOR_W-1:0];
      end
      MODE_EXP: begin
        x = (dens_q * az) >> COORD_FRAC_BITS;
        return decay_q16(x);
      end
      MODE_EXP2: begin
        x = (dens_q * az) >> COORD_FRAC_BITS;
        if (x >= (64'd4 << 16)) begin
          return '0;
        end
        return decay_q16((x * x) >> 16);
      end
      default: return ONE_Q16;
    endcase
  endfunction

  initial begin
    for (int k = 0; k <= SEGS; k++) begin
      decay_rom[k] = decay_point(k);
    end
  end

  // Compare results, queue predictions, track register writes
  always @(posedge clk) begin
    if (!rst_n) begin
      mode_q      = MODE_LINEAR;
      start_q     = 64'sd0;
      end_q       = 64'sd65536;
      dens_q      = 64'd65536;
      refresh_recip();
      fog_expect_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (fog_expect_q.size() == 0) begin
          err_total++;
          $display("%0t: result transaction with nothing expected: expected none, actual %0d",
                   $time, out_tdata[FACTOR_W-1:0]);
        end else begin
          want = fog_expect_q.pop_front();
          seen_total++;
          if (out_tdata[FACTOR_W-1:0] !== want.factor) begin
            err_total++;
            $display("%0t: fog_factor mismatch: expected %0d, actual %0d",
                     $time, want.factor, out_tdata[FACTOR_W-1:0]);
          end
          if (out_tdata[OUT_DATA_W-1:FACTOR_W] !== '0) begin
            err_total++;
            $display("%0t: tdata pad mismatch: expected 0, actual %0h",
                     $time, out_tdata[OUT_DATA_W-1:FACTOR_W]);
          end
          if (out_tlast !== want.last) begin
            err_total++;
            $display("%0t: last_out mismatch: expected %0b, actual %0b",
                     $time, want.last, out_tlast);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        fog_expect_q.push_back('{factor: predict_fog(in_tdata), last: in_tlast});
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE: mode_q = cfg_wdata[1:0];
          REG_START: begin
            start_q = widen_signed(cfg_wdata);
            refresh_recip();
          end
          REG_END: begin
            end_q = widen_signed(cfg_wdata);
            refresh_recip();
          end
          REG_DENSITY: dens_q = 64'(cfg_wdata);
          default: ;
        endcase
      end
    end
    pending    <= fog_expect_q.size();
    checked    <= seen_total;
    mismatches <= err_total;
  end

endmodule

// File: tb/sv/tb_vertex_fog_factor.sv
module tb_vertex_fog_factor;
  import vff_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_ITEMS  = 1650;
  localparam int STALL_LIMIT = 4000;

  // Unused fog mode code, expected to give no fog
  localparam logic [1:0] MODE_NO_FOG = 2'd3;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tlast   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  int unsigned pending;
  int unsigned checked;
  int unsigned mismatches;

  int          send_idle_pct = 20;
  int          recv_idle_pct = 82;
  int unsigned stall_cycles  = 0;
  int unsigned vertex_cnt    = 0;
  int unsigned setting_cnt   = 0;
  int unsigned random_sent   = 0;
  int unsigned batch_len;

  // Current settings, used to aim coordinates at the interesting range
  logic [1:0]  cur_mode  = MODE_LINEAR;
  logic [31:0] cur_start = 32'd0;
  logic [31:0] cur_end   = 32'd65536;
  logic [31:0] cur_dens  = 32'd65536;

  vertex_fog_factor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // fog_coord [31:0]
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),  // fog_factor [16:0], zero [23:17]
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  vff_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .pending   (pending),
    .checked   (checked),
    .mismatches(mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver backpressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Abort when no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding",
               $time, stall_cycles, pending);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Log-uniform magnitude, random sign, sometimes an extreme
  function automatic logic [31:0] rand_wide();
    logic [31:0] v;
    case ($urandom_range(0, 19))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom;
      default: begin
        v = $urandom >> $urandom_range(0, 31);
        return ($urandom_range(0, 1) == 1) ? -v : v;
      end
    endcase
  endfunction

  // Coordinate aimed at the live part of the current fog curve, or wide noise
  function automatic logic [31:0] rand_coord();
    logic signed [63:0] lo;
    logic signed [63:0] hi;
    logic signed [63:0] w;
    logic signed [63:0] c;
    logic [63:0]        tx;
    if ($urandom_range(0, 99) < 40) begin
      return rand_wide();
    end
    if (cur_mode == MODE_LINEAR) begin
      lo = {{32{cur_start[31]}}, cur_start};
      hi = {{32{cur_end[31]}}, cur_end};
      w  = 64'($urandom_range(0, 1280));
      c  = lo + (((hi - lo) * (w - 128)) >>> 10);
    end else if (cur_dens == 0) begin
      c = {{32{1'b0}}, $urandom};
    end else begin
      tx = $urandom_range(0, (cur_mode == MODE_EXP2) ? (5 << 16) : (20 << 16));
      c  = $signed((tx << 16) / 64'(cur_dens));
    end
    if ($urandom_range(0, 3) == 0) begin
      c = -c;
    end
    if (c > 64'sd2147483647) begin
      c = 64'sd2147483647;
    end
    if (c < -64'sd2147483648) begin
      c = -64'sd2147483648;
    end
    return c[31:0];
  endfunction

  // Hold until the reciprocal divider has released the input
  task automatic wait_ready();
    do @(posedge clk); while (!in_tready);
  endtask

  // One register write, then cfg_we low again before returning
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Drain the pipeline, then load a full fog setting
  task automatic program_fog(input logic [1:0] mode, input logic [31:0] start_v,
                             input logic [31:0] end_v, input logic [31:0] dens_v);
    in_tvalid <= 1'b0;
    // Let the last accepted vertex show up in the outstanding count
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    write_reg(REG_MODE, {30'd0, mode});
    write_reg(REG_START, start_v);
    wait_ready();
    write_reg(REG_END, end_v);
    wait_ready();
    write_reg(REG_DENSITY, dens_v);
    cur_mode  = mode;
    cur_start = start_v;
    cur_end   = end_v;
    cur_dens  = dens_v;
    setting_cnt++;
  endtask

  // Present one vertex after a random gap, hold until accepted
  task automatic send_vertex(input logic [31:0] coord, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= coord;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    vertex_cnt++;
  endtask

  // Random fog setting; unused mode now and then
  task automatic program_random();
    logic [1:0]  mode;
    logic [31:0] start_v;
    logic [31:0] end_v;
    logic [31:0] dens_v;
    case ($urandom_range(0, 9))
      0, 1, 2: mode = MODE_LINEAR;
      3, 4, 5: mode = MODE_EXP;
      6, 7, 8: mode = MODE_EXP2;
      default: mode = MODE_NO_FOG;
    endcase
    start_v = rand_wide();
    end_v   = ($urandom_range(0, 99) < 15) ? start_v : rand_wide();
    case ($urandom_range(0, 19))
      0:       dens_v = 32'd0;
      1:       dens_v = 32'hFFFF_FFFF;
      default: dens_v = $urandom >> $urandom_range(0, 31);
    endcase
    program_fog(mode, start_v, end_v, dens_v);
  endtask

  initial begin
    // Reset, then let the reset-time reciprocal settle
    rst_n <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    wait_ready();

    // Reset settings: linear from 0 to 1.0
    send_vertex(32'h0000_0000, 1'b0);
    send_vertex(32'h0000_8000, 1'b0);
    send_vertex(32'h0001_0000, 1'b0);
    send_vertex(32'hFFFF_0000, 1'b1);
    send_vertex(32'h8000_0000, 1'b0);
    send_vertex(32'h7FFF_FFFF, 1'b1);

    // Start equals end: zero, positive and negative numerator
    program_fog(MODE_LINEAR, 32'h0001_0000, 32'h0001_0000, 32'd65536);
    send_vertex(32'h0001_0000, 1'b0);
    send_vertex(32'h0000_0000, 1'b0);
    send_vertex(32'h0002_0000, 1'b1);

    // Extreme range with start above end
    program_fog(MODE_LINEAR, 32'h7FFF_FFFF, 32'h8000_0000, 32'd65536);
    send_vertex(32'h0000_0000, 1'b0);
    send_vertex(32'h4000_0000, 1'b1);

    // Exp at full density, down to saturation
    program_fog(MODE_EXP, 32'd0, 32'd65536, 32'hFFFF_FFFF);
    send_vertex(32'h0000_0000, 1'b0);
    send_vertex(32'h0000_0001, 1'b0);
    send_vertex(32'h8000_0000, 1'b1);

    // Exp2 around the cutoff at x = 4
    program_fog(MODE_EXP2, 32'd0, 32'd65536, 32'd65536);
    send_vertex(32'h0002_0000, 1'b0);
    send_vertex(32'h0003_FFFF, 1'b0);
    send_vertex(32'h0004_0000, 1'b0);
    send_vertex(32'hFFFF_0000, 1'b1);

    // Unused mode gives no fog
    program_fog(MODE_NO_FOG, 32'd0, 32'd65536, 32'd65536);
    send_vertex(32'h1234_5678, 1'b0);
    send_vertex(32'h0000_0000, 1'b1);

    // Exp with zero density
    program_fog(MODE_EXP, 32'd0, 32'd65536, 32'd0);
    send_vertex(32'h7FFF_FFFF, 1'b1);

    // Random batches; idle pattern moves through three profiles
    while (random_sent < RAND_ITEMS) begin
      case (random_sent * 3 / RAND_ITEMS)
        0: begin
          send_idle_pct <= 20;
          recv_idle_pct <= 82;
        end
        1: begin
          send_idle_pct <= 82;
          recv_idle_pct <= 20;
        end
        default: begin
          send_idle_pct <= 0;
          recv_idle_pct <= 0;
        end
      endcase
      program_random();
      batch_len = $urandom_range(20, 80);
      repeat (batch_len) begin
        send_vertex(rand_coord(), ($urandom_range(0, 7) == 0));
        random_sent++;
      end
    end

    // Drain and let the pipeline settle
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d vertices over %0d fog settings in linear, exp, exp2 and unused mode",
             vertex_cnt, setting_cnt);
    $display("Compared %0d fog factors under three idle profiles, %0d mismatches",
             checked, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: vertex_fog_factor.f
hdl/vff_pkg.sv
hdl/vff_recip.sv
hdl/vff_lin.sv
hdl/vff_exp.sv
hdl/vertex_fog_factor.sv
hdl/vff_checker.sv
tb/sv/vff_checker.sv
tb/sv/tb_vertex_fog_factor.sv
